/* rtl/excitable_media_cell_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the excitable media cell.
// Each macro checks one clocked implication and is empty when ASSERT_OFF is set.
// ---------------------------------------------------------------------------
`ifndef EXCITABLE_MEDIA_CELL_ASSERT_SVH
`define EXCITABLE_MEDIA_CELL_ASSERT_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define EMC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("excitable_media_cell: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define EMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("excitable_media_cell: next-cycle check failed");

`else

`define EMC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define EMC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/emc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// emc_pkg
// Shared widths, constants, register codes and controller command types.
// ---------------------------------------------------------------------------
package emc_pkg;

   localparam int MAX_NEIGHBORS = 6;
   localparam int STATE_W       = 4;
   localparam int NEIGH_FIELD_W = 24;
   localparam int SLOTS         = NEIGH_FIELD_W / STATE_W;
   localparam int HIT_W         = $clog2(SLOTS + 1);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_EXCITE_THRESHOLD = 3'd0,
      REG_SPARK_CHANCE     = 3'd1,
      REG_REFRACTORY_LEN   = 3'd2,
      REG_TICK_PERIOD_MS   = 3'd3,
      REG_HUE_SEL          = 3'd4,
      REG_KNOCK_MODE       = 3'd5,
      REG_PRESENCE_SEED    = 3'd6,
      REG_RNG_SEED         = 3'd7
   } csr_index_type;

   // Register reset values and substitutes for a zero setting.
   localparam logic [7:0]  RST_EXCITE_THRESHOLD = 8'd1;
   localparam logic [7:0]  RST_SPARK_CHANCE     = 8'd2;
   localparam logic [7:0]  RST_REFRACTORY_LEN   = 8'd3;
   localparam logic [14:0] RST_TICK_PERIOD_MS   = 15'd1000;
   localparam logic [7:0]  RST_HUE_SEL          = 8'd160;
   localparam logic [31:0] RNG_DEFAULT_SEED     = 32'hA5A5A5A5;
   localparam logic [7:0]  DEFAULT_THRESHOLD    = 8'd1;
   localparam logic [7:0]  DEFAULT_REFRACTORY   = 8'd3;
   localparam logic [14:0] DEFAULT_PERIOD_MS    = 15'd1000;

   localparam logic [7:0]  CELL_QUIESCENT = 8'd0;
   localparam logic [7:0]  CELL_EXCITED   = 8'd1;
   localparam logic [3:0]  NEIGH_EXCITED  = 4'd1;

   localparam logic [31:0] ATTACK_MS      = 32'd200;
   localparam logic [7:0]  FULL_LEVEL     = 8'd255;
   localparam logic [7:0]  REFR_NUMERATOR = 8'd140;
   localparam logic [7:0]  QUIET_LEVEL    = 8'd25;
   localparam logic [5:0]  STRIKE_MS      = 6'd40;
   localparam int          HUE_SPAN       = 43;

   // floor(x / 200) = (x * 5243) >> 20 for every x below 43799.
   localparam logic [12:0] RECIP_200   = 13'd5243;
   localparam int          RECIP_SHIFT = 20;

   localparam int DIV_STEPS = 8;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef struct packed {
      logic capture;
      logic load;
      logic step;
      logic prep;
      logic div_step;
      logic level;
      logic mult;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

   // Exact floor(x / 255) for any product of two bytes.
   function automatic logic [7:0] div_by_255(input logic [15:0] x);
      logic [16:0] sum;
      sum = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
      return sum[15:8];
   endfunction

endpackage

/* rtl/emc_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// emc_req_if / emc_rsp_if
// Valid/ready channels for tick beats in and pixel result beats out.
// ---------------------------------------------------------------------------
interface emc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_ms;
   logic [7:0]  tick_divider;
   logic        presence_rising;
   logic [2:0]  neighbor_count;
   logic [23:0] neighbor_states;

   modport source (output valid, output now_ms, output tick_divider,
                   output presence_rising, output neighbor_count,
                   output neighbor_states, input ready);
   modport sink   (input valid, input now_ms, input tick_divider,
                   input presence_rising, input neighbor_count,
                   input neighbor_states, output ready);
endinterface

interface emc_rsp_if;
   logic        valid;
   logic        ready;
   logic        send_now;
   logic        strike_request;
   logic [5:0]  strike_pulse_ms;
   logic        suppress_light;
   logic [3:0]  tx_state;
   logic [15:0] generation_out;
   logic [15:0] phase_ms;
   logic [7:0]  intensity;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [7:0]  white;

   modport source (output valid, output send_now, output strike_request,
                   output strike_pulse_ms, output suppress_light, output tx_state,
                   output generation_out, output phase_ms, output intensity,
                   output red, output green, output blue, output white,
                   input ready);
   modport sink   (input valid, input send_now, input strike_request,
                   input strike_pulse_ms, input suppress_light, input tx_state,
                   input generation_out, input phase_ms, input intensity,
                   input red, input green, input blue, input white,
                   output ready);
endinterface

/* rtl/emc_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// emc_ctrl
// Sequencer that walks one tick beat through the datapath phases.
// ---------------------------------------------------------------------------
module emc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  emc_pkg::status_type  status,
   output emc_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_STEP,
      S_PREP,
      S_DIVIDE,
      S_LEVEL,
      S_MULT,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_STEP;
         end
         S_STEP: begin
            cmd.step = 1'b1;
            state_in = S_PREP;
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_DIVIDE;
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = S_LEVEL;
            end
         end
         S_LEVEL: begin
            cmd.level = 1'b1;
            state_in  = S_MULT;
         end
         S_MULT: begin
            cmd.mult = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // Hold here while the previous result beat is still waiting.
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/emc_datapath.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// emc_datapath
// Cell state, configuration, step logic, level divider and color wheel.
// ---------------------------------------------------------------------------
module emc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  emc_pkg::cmd_type                    cmd,
   output emc_pkg::status_type                 status,
   input  logic                                csr_write_enable,
   input  logic [emc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [emc_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic [31:0]                         now_ms,
   input  logic [7:0]                          tick_divider,
   input  logic                                presence_rising,
   input  logic [2:0]                          neighbor_count,
   input  logic [emc_pkg::NEIGH_FIELD_W-1:0]   neighbor_states,
   output logic                                send_now,
   output logic                                strike_request,
   output logic [5:0]                          strike_pulse_ms,
   output logic                                suppress_light,
   output logic [3:0]                          tx_state,
   output logic [15:0]                         generation_out,
   output logic [15:0]                         phase_ms,
   output logic [7:0]                          intensity,
   output logic [7:0]                          red,
   output logic [7:0]                          green,
   output logic [7:0]                          blue,
   output logic [7:0]                          white
);

   localparam logic [7:0] SEG1 = 8'(emc_pkg::HUE_SPAN);
   localparam logic [7:0] SEG2 = 8'(2 * emc_pkg::HUE_SPAN);
   localparam logic [7:0] SEG3 = 8'(3 * emc_pkg::HUE_SPAN);
   localparam logic [7:0] SEG4 = 8'(4 * emc_pkg::HUE_SPAN);
   localparam logic [7:0] SEG5 = 8'(5 * emc_pkg::HUE_SPAN);

   // Configuration registers.
   logic [7:0]  threshold_ff, spark_ff, refr_ff, hue_ff;
   logic [14:0] period_cfg_ff;
   logic        knock_ff, seed_en_ff;

   // Captured tick beat.
   logic [31:0] now_ff;
   logic [7:0]  div_ff;
   logic        pres_ff;
   logic [2:0]  nn_ff;
   logic [emc_pkg::NEIGH_FIELD_W-1:0] nb_ff;

   // Cell state.
   logic [7:0]  cell_ff, cell_in;
   logic [15:0] count_ff;
   logic [31:0] rng_ff, rng_in;
   logic [31:0] last_ff, excite_ff;
   logic        seed_ff;

   // Working registers.
   logic [22:0] period_ff;
   logic        send_ff;
   logic        dt_big_ff;
   logic [28:0] recip_ff;
   logic [2:0]  seg_ff;
   logic [7:0]  rem6_ff;
   logic [7:0]  quo_ff, rem_ff;
   logic [emc_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic [7:0]  inten_ff;
   logic [15:0] pq_ff, pt_ff;

   // Output payload registers.
   logic        send_out_ff, strike_out_ff, knock_out_ff;
   logic [5:0]  pulse_out_ff;
   logic [3:0]  tx_out_ff;
   logic [15:0] gen_out_ff, phase_out_ff;
   logic [7:0]  inten_out_ff, red_out_ff, green_out_ff, blue_out_ff, white_out_ff;

   // Combinational terms.
   logic [7:0]  k_eff, refr_eff;
   logic [14:0] period_eff;
   logic [7:0]  tdiv_eff;
   logic [31:0] elapsed;
   logic        take_step;
   logic [31:0] x1, x2;
   logic [emc_pkg::HIT_W-1:0] hits;
   logic        excite_now;
   logic [31:0] dt;
   logic [15:0] attack_x;
   logic [2:0]  seg_in;
   logic [7:0]  seg_base, hue_rem;
   logic [8:0]  rem_try, rem_diff;
   logic        rem_ge;
   logic [7:0]  level_in;
   logic [7:0]  wq, wt;
   logic [7:0]  r_in, g_in, b_in, w_in;

   assign k_eff      = (threshold_ff != 8'd0) ? threshold_ff : emc_pkg::DEFAULT_THRESHOLD;
   assign refr_eff   = (refr_ff != 8'd0) ? refr_ff : emc_pkg::DEFAULT_REFRACTORY;
   assign period_eff = (period_cfg_ff != 15'd0) ? period_cfg_ff
                                                : emc_pkg::DEFAULT_PERIOD_MS;
   assign tdiv_eff   = (div_ff != 8'd0) ? div_ff : 8'd1;

   assign elapsed   = now_ff - last_ff;
   assign take_step = (elapsed >= {9'b0, period_ff});

   // xorshift32 advance.
   assign x1     = rng_ff ^ (rng_ff << 13);
   assign x2     = x1 ^ (x1 >> 17);
   assign rng_in = x2 ^ (x2 << 5);

   always_comb begin
      int lim;
      lim  = (int'(nn_ff) > emc_pkg::MAX_NEIGHBORS) ? emc_pkg::MAX_NEIGHBORS : int'(nn_ff);
      hits = '0;
      for (int i = 0; i < emc_pkg::SLOTS; i++) begin
         if (i < lim && nb_ff[i*emc_pkg::STATE_W +: emc_pkg::STATE_W] == emc_pkg::NEIGH_EXCITED) begin
            hits = hits + emc_pkg::HIT_W'(1);
         end
      end
   end

   assign excite_now = ({{(8 - emc_pkg::HIT_W){1'b0}}, hits} >= k_eff)
                       || (rng_in[7:0] < spark_ff) || seed_ff;

   always_comb begin
      if (cell_ff == emc_pkg::CELL_QUIESCENT) begin
         cell_in = excite_now ? emc_pkg::CELL_EXCITED : emc_pkg::CELL_QUIESCENT;
      end else if ({1'b0, cell_ff} >= ({1'b0, refr_eff} + 9'd1)) begin
         cell_in = emc_pkg::CELL_QUIESCENT;
      end else begin
         cell_in = cell_ff + 8'd1;
      end
   end

   // Attack ramp: dt * 255, later scaled by the reciprocal of 200.
   assign dt       = now_ff - excite_ff;
   assign attack_x = {dt[7:0], 8'b0} - {8'b0, dt[7:0]};

   always_comb begin
      if (hue_ff >= SEG5) begin
         seg_in = 3'd5; seg_base = SEG5;
      end else if (hue_ff >= SEG4) begin
         seg_in = 3'd4; seg_base = SEG4;
      end else if (hue_ff >= SEG3) begin
         seg_in = 3'd3; seg_base = SEG3;
      end else if (hue_ff >= SEG2) begin
         seg_in = 3'd2; seg_base = SEG2;
      end else if (hue_ff >= SEG1) begin
         seg_in = 3'd1; seg_base = SEG1;
      end else begin
         seg_in = 3'd0; seg_base = 8'd0;
      end
   end
   assign hue_rem = hue_ff - seg_base;

   // Restoring divider for 140 / cell_state, one quotient bit per cycle.
   assign rem_try  = {rem_ff, quo_ff[7]};
   assign rem_diff = rem_try - {1'b0, cell_ff};
   assign rem_ge   = (rem_try >= {1'b0, cell_ff});
   assign status.div_done = (cnt_ff == emc_pkg::DIV_CNT_W'(emc_pkg::DIV_STEPS - 1));

   always_comb begin
      if (cell_ff == emc_pkg::CELL_EXCITED) begin
         level_in = dt_big_ff ? emc_pkg::FULL_LEVEL
                              : recip_ff[emc_pkg::RECIP_SHIFT +: 8];
      end else if (cell_ff != emc_pkg::CELL_QUIESCENT) begin
         level_in = quo_ff;
      end else begin
         level_in = emc_pkg::QUIET_LEVEL;
      end
   end

   assign wq = emc_pkg::div_by_255(pq_ff);
   assign wt = emc_pkg::div_by_255(pt_ff);

   always_comb begin
      case (seg_ff)
         3'd0:    begin r_in = inten_ff; g_in = wt;       b_in = 8'd0;     end
         3'd1:    begin r_in = wq;       g_in = inten_ff; b_in = 8'd0;     end
         3'd2:    begin r_in = 8'd0;     g_in = inten_ff; b_in = wt;       end
         3'd3:    begin r_in = 8'd0;     g_in = wq;       b_in = inten_ff; end
         3'd4:    begin r_in = wt;       g_in = 8'd0;     b_in = inten_ff; end
         default: begin r_in = inten_ff; g_in = 8'd0;     b_in = wq;       end
      endcase
      w_in = 8'd0;
      if (cell_ff == emc_pkg::CELL_QUIESCENT) begin
         w_in = inten_ff;
         r_in = 8'd0;
         g_in = 8'd0;
         b_in = 8'd0;
      end
      if (knock_ff) begin
         r_in = 8'd0;
         g_in = 8'd0;
         b_in = 8'd0;
         w_in = 8'd0;
      end
   end

   // Configuration and cell state.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= emc_pkg::RST_EXCITE_THRESHOLD;
         spark_ff      <= emc_pkg::RST_SPARK_CHANCE;
         refr_ff       <= emc_pkg::RST_REFRACTORY_LEN;
         period_cfg_ff <= emc_pkg::RST_TICK_PERIOD_MS;
         hue_ff        <= emc_pkg::RST_HUE_SEL;
         knock_ff      <= 1'b0;
         seed_en_ff    <= 1'b0;
         rng_ff        <= emc_pkg::RNG_DEFAULT_SEED;
         cell_ff       <= emc_pkg::CELL_QUIESCENT;
         count_ff      <= 16'd0;
         last_ff       <= 32'd0;
         excite_ff     <= 32'd0;
         seed_ff       <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (emc_pkg::csr_index_type'(csr_index))
               emc_pkg::REG_EXCITE_THRESHOLD: threshold_ff  <= csr_write_data[7:0];
               emc_pkg::REG_SPARK_CHANCE:     spark_ff      <= csr_write_data[7:0];
               emc_pkg::REG_REFRACTORY_LEN:   refr_ff       <= csr_write_data[7:0];
               emc_pkg::REG_TICK_PERIOD_MS:   period_cfg_ff <= csr_write_data[14:0];
               emc_pkg::REG_HUE_SEL:          hue_ff        <= csr_write_data[7:0];
               emc_pkg::REG_KNOCK_MODE:       knock_ff      <= csr_write_data[0];
               emc_pkg::REG_PRESENCE_SEED:    seed_en_ff    <= csr_write_data[0];
               emc_pkg::REG_RNG_SEED: begin
                  rng_ff <= (csr_write_data != 32'd0) ? csr_write_data
                                                      : emc_pkg::RNG_DEFAULT_SEED;
               end
            endcase
         end
         if (cmd.load) begin
            if (seed_en_ff && pres_ff) begin
               seed_ff <= 1'b1;
            end
            if (last_ff == 32'd0) begin
               last_ff <= now_ff;
            end
         end
         if (cmd.step && take_step) begin
            last_ff  <= now_ff;
            count_ff <= count_ff + 16'd1;
            cell_ff  <= cell_in;
            if (cell_ff == emc_pkg::CELL_QUIESCENT) begin
               rng_ff <= rng_in;
               if (excite_now) begin
                  excite_ff <= now_ff;
                  seed_ff   <= 1'b0;
               end
            end
         end
         if (cmd.prep) begin
            cnt_ff <= '0;
         end else if (cmd.div_step) begin
            cnt_ff <= cnt_ff + emc_pkg::DIV_CNT_W'(1);
         end
      end
   end

   // Beat capture, working values and result payload.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         now_ff  <= now_ms;
         div_ff  <= tick_divider;
         pres_ff <= presence_rising;
         nn_ff   <= neighbor_count;
         nb_ff   <= neighbor_states;
      end
      if (cmd.load) begin
         period_ff <= {8'b0, period_eff} * {15'b0, tdiv_eff};
      end
      if (cmd.step) begin
         send_ff <= take_step && (cell_in == emc_pkg::CELL_EXCITED);
      end
      if (cmd.prep) begin
         dt_big_ff <= (dt >= emc_pkg::ATTACK_MS);
         recip_ff  <= {13'b0, attack_x} * {16'b0, emc_pkg::RECIP_200};
         seg_ff    <= seg_in;
         rem6_ff   <= (hue_rem << 2) + (hue_rem << 1);
         quo_ff    <= emc_pkg::REFR_NUMERATOR;
         rem_ff    <= 8'd0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_ge ? rem_diff[7:0] : rem_try[7:0];
         quo_ff <= {quo_ff[6:0], rem_ge};
      end
      if (cmd.level) begin
         inten_ff <= level_in;
      end
      if (cmd.mult) begin
         pq_ff <= {8'b0, inten_ff} * {8'b0, emc_pkg::FULL_LEVEL - rem6_ff};
         pt_ff <= {8'b0, inten_ff} * {8'b0, rem6_ff};
      end
      if (cmd.emit) begin
         send_out_ff   <= send_ff;
         strike_out_ff <= send_ff && knock_ff;
         pulse_out_ff  <= (send_ff && knock_ff) ? emc_pkg::STRIKE_MS : 6'd0;
         knock_out_ff  <= knock_ff;
         tx_out_ff     <= cell_ff[3:0];
         gen_out_ff    <= count_ff;
         phase_out_ff  <= elapsed[15:0];
         inten_out_ff  <= inten_ff;
         red_out_ff    <= r_in;
         green_out_ff  <= g_in;
         blue_out_ff   <= b_in;
         white_out_ff  <= w_in;
      end
   end

   assign send_now        = send_out_ff;
   assign strike_request  = strike_out_ff;
   assign strike_pulse_ms = pulse_out_ff;
   assign suppress_light  = knock_out_ff;
   assign tx_state        = tx_out_ff;
   assign generation_out  = gen_out_ff;
   assign phase_ms        = phase_out_ff;
   assign intensity       = inten_out_ff;
   assign red             = red_out_ff;
   assign green           = green_out_ff;
   assign blue            = blue_out_ff;
   assign white           = white_out_ff;

endmodule

/* rtl/excitable_media_cell.sv */
// An accepted tick beat passes through the load, step, prepare, divide, level, multiply and emit
//   states before its result is presented; the divide state runs the eight iterations of the
//   restoring divider for the refractory level. No new tick beat is taken until the last is emitted.
// Reset (synchronous, active high) loads the configuration and cell-state registers with their
//   default values and leaves the cell quiescent with no result pending; there is no clearing pass.
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// excitable_media_cell
// One cell of a Greenberg-Hastings excitable medium with a single RGBW pixel.
// ---------------------------------------------------------------------------
`include "excitable_media_cell_assert.svh"

module excitable_media_cell (
   input  logic                              clock,
   input  logic                              reset,
   emc_req_if.sink                           req_ch,
   emc_rsp_if.source                         rsp_ch,
   input  logic                              csr_write_enable,
   input  logic [emc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [emc_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   // The controller sequences each beat through load, step, prepare, divide,
   // level, multiply and emit phases. The datapath holds the cell state and
   // the result register, so a finished beat waits there while the next tick
   // beat is already accepted.
   emc_pkg::cmd_type    cmd;
   emc_pkg::status_type status;

   emc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The step decision, spark draw and neighbor count all settle in the step
   // phase; the level and color math follow from the updated state.
   emc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .now_ms           (req_ch.now_ms),
      .tick_divider     (req_ch.tick_divider),
      .presence_rising  (req_ch.presence_rising),
      .neighbor_count   (req_ch.neighbor_count),
      .neighbor_states  (req_ch.neighbor_states),
      .send_now         (rsp_ch.send_now),
      .strike_request   (rsp_ch.strike_request),
      .strike_pulse_ms  (rsp_ch.strike_pulse_ms),
      .suppress_light   (rsp_ch.suppress_light),
      .tx_state         (rsp_ch.tx_state),
      .generation_out   (rsp_ch.generation_out),
      .phase_ms         (rsp_ch.phase_ms),
      .intensity        (rsp_ch.intensity),
      .red              (rsp_ch.red),
      .green            (rsp_ch.green),
      .blue             (rsp_ch.blue),
      .white            (rsp_ch.white)
   );

   // Only one beat is in flight, so the input closes right after an accept.
   `EMC_ASSERT_NEXT(a_single_beat_in_flight, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)

   // An emit always leaves a result beat on the output.
   `EMC_ASSERT_NEXT(a_emit_shows_result, clock, reset, cmd.emit, rsp_ch.valid)

   // A strike is requested only on an excited step in knock mode.
   `EMC_ASSERT_IMPLY(a_strike_rule, clock, reset, rsp_ch.valid, rsp_ch.strike_request == (rsp_ch.send_now && rsp_ch.suppress_light))

   // White light and the colored channels never show together.
   `EMC_ASSERT_IMPLY(a_white_excludes_color, clock, reset, rsp_ch.valid && rsp_ch.white != 8'd0, rsp_ch.red == 8'd0 && rsp_ch.green == 8'd0 && rsp_ch.blue == 8'd0)

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for one excitable media cell. Tick beats are queued by
// a stimulus process and fed through the request channel. Each accepted beat
// is run through a behavioral copy of the cell, and the pixel it should yield
// is compared field by field with the beat that leaves the result channel.
// ---------------------------------------------------------------------------
module testbench;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 12;
   localparam int LIMIT_CYCLES  = 400000;
   // This is ample time for the block to answer a tick it has taken.
   localparam int SETTLE_CYCLES = 30;
   localparam int MAX_REPORTS   = 10;

   // The long receiver hold starts after this many results, which lands in
   // the middle of the third random phase while ticks are still queued.
   localparam int HOLD_AT     = 170;
   localparam int HOLD_CYCLES = 300;

   localparam int PHASES       = 13;
   localparam int PHASE_TICKS  = 60;
   localparam int LONG_PHASE   = 6;
   localparam int LONG_TICKS   = 300;
   localparam int DRAIN_PHASE  = 4;
   localparam int HUE_SEGMENTS = 6;

   typedef struct packed {
      logic        drain_first;
      logic [31:0] now_ms;
      logic [7:0]  tick_divider;
      logic        presence_rising;
      logic [2:0]  neighbor_count;
      logic [23:0] neighbor_states;
   } tick_beat_type;

   typedef struct packed {
      logic        send_now;
      logic        strike_request;
      logic [5:0]  strike_pulse_ms;
      logic        suppress_light;
      logic [3:0]  tx_state;
      logic [15:0] generation_out;
      logic [15:0] phase_ms;
      logic [7:0]  intensity;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  white;
   } pixel_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                            csr_write_enable;
   logic [emc_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [emc_pkg::CSR_DATA_W-1:0]  csr_write_data;

   emc_req_if req_ch ();
   emc_rsp_if rsp_ch ();

   excitable_media_cell dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Ticks waiting to be offered, and pixels predicted for ticks already taken.
   tick_beat_type  tick_queue[$];
   pixel_beat_type due_pixels[$];

   int  fault_count  = 0;
   int  results_seen = 0;
   int  cycle_count  = 0;
   int  send_gap     = 0;
   int  stall_left   = 0;
   int  hold_seen    = 0;
   int  hold_left    = 0;
   logic hold_on     = 1'b0;
   // When set, neither side inserts idle cycles any more.
   logic calm = 1'b0;

   // Register copies held by the predictor.
   logic [7:0]  threshold_cfg;
   logic [7:0]  spark_cfg;
   logic [7:0]  refractory_cfg;
   logic [14:0] period_cfg;
   logic [7:0]  hue_cfg;
   logic        knock_cfg;
   logic        seed_enable_cfg;

   // Cell state held by the predictor.
   logic [7:0]  cur_state;
   logic [15:0] steps_taken;
   logic [31:0] spark_word;
   logic [31:0] last_step_ms;
   logic [31:0] excited_at_ms;
   logic        seed_latched;

   // Runs one tick through the cell and returns the pixel beat it produces.
   function automatic pixel_beat_type step_cell(input tick_beat_type t);
      pixel_beat_type p;
      logic [31:0] period, needed, span, limit, hits, draw;
      logic [31:0] dt, level, seg, rem, qv, tv;
      logic [7:0]  thr;
      int          slots;
      p = '0;
      period = (period_cfg == '0) ? 32'(emc_pkg::DEFAULT_PERIOD_MS) : 32'(period_cfg);
      // A presence edge is latched before the step is considered.
      if (seed_enable_cfg && t.presence_rising) seed_latched = 1'b1;
      // A zero start time means the cell has not started yet.
      if (last_step_ms == 32'd0) last_step_ms = t.now_ms;
      needed = period * ((t.tick_divider == 8'd0) ? 32'd1 : 32'(t.tick_divider));
      span = t.now_ms - last_step_ms;
      if (span >= needed) begin
         last_step_ms = t.now_ms;
         steps_taken = steps_taken + 16'd1;
         limit = 32'd1 + ((refractory_cfg == 8'd0) ? 32'(emc_pkg::DEFAULT_REFRACTORY)
                                                     : 32'(refractory_cfg));
         if (cur_state == emc_pkg::CELL_QUIESCENT) begin
            slots = (t.neighbor_count > emc_pkg::MAX_NEIGHBORS) ? emc_pkg::MAX_NEIGHBORS
                                                                : int'(t.neighbor_count);
            hits = 32'd0;
            for (int i = 0; i < slots; i++)
               if (t.neighbor_states[4*i +: 4] == emc_pkg::NEIGH_EXCITED) hits++;
            // The xorshift generator only advances on a quiescent step.
            draw = spark_word ^ (spark_word << 13);
            draw = draw ^ (draw >> 17);
            draw = draw ^ (draw << 5);
            spark_word = draw;
            thr = (threshold_cfg == 8'd0) ? emc_pkg::DEFAULT_THRESHOLD : threshold_cfg;
            if (hits >= 32'(thr) || draw[7:0] < spark_cfg || seed_latched) begin
               cur_state = emc_pkg::CELL_EXCITED;
               excited_at_ms = t.now_ms;
               seed_latched = 1'b0;
            end
         end else if (32'(cur_state) >= limit) begin
            cur_state = emc_pkg::CELL_QUIESCENT;
         end else begin
            // With the longest refractory run this wraps from 255 to zero.
            cur_state = cur_state + 8'd1;
         end
         if (cur_state == emc_pkg::CELL_EXCITED) begin
            p.send_now = 1'b1;
            if (knock_cfg) begin
               p.strike_request = 1'b1;
               p.strike_pulse_ms = emc_pkg::STRIKE_MS;
            end
         end
      end

      // Brightness: a linear attack while excited, a falling level while
      // refractory and a dim glow while quiescent.
      if (cur_state == emc_pkg::CELL_EXCITED) begin
         dt = t.now_ms - excited_at_ms;
         level = (dt >= emc_pkg::ATTACK_MS) ? 32'(emc_pkg::FULL_LEVEL)
                                            : dt * 32'(emc_pkg::FULL_LEVEL) / emc_pkg::ATTACK_MS;
      end else if (cur_state > emc_pkg::CELL_EXCITED) begin
         level = 32'(emc_pkg::REFR_NUMERATOR) / 32'(cur_state);
      end else begin
         level = 32'(emc_pkg::QUIET_LEVEL);
      end

      // Six-segment hue wheel scaled to the brightness.
      seg = 32'(hue_cfg) / emc_pkg::HUE_SPAN;
      rem = (32'(hue_cfg) % emc_pkg::HUE_SPAN) * HUE_SEGMENTS;
      qv = level * (32'(emc_pkg::FULL_LEVEL) - rem) / 32'(emc_pkg::FULL_LEVEL);
      tv = level * rem / 32'(emc_pkg::FULL_LEVEL);
      case (seg)
         32'd0: begin
            p.red = level[7:0];
            p.green = tv[7:0];
         end
         32'd1: begin
            p.red = qv[7:0];
            p.green = level[7:0];
         end
         32'd2: begin
            p.green = level[7:0];
            p.blue = tv[7:0];
         end
         32'd3: begin
            p.green = qv[7:0];
            p.blue = level[7:0];
         end
         32'd4: begin
            p.red = tv[7:0];
            p.blue = level[7:0];
         end
         default: begin
            p.red = level[7:0];
            p.blue = qv[7:0];
         end
      endcase
      // A quiescent cell shows only white, and knock mode shows nothing.
      if (cur_state == emc_pkg::CELL_QUIESCENT) begin
         p.white = level[7:0];
         p.red = 8'd0;
         p.green = 8'd0;
         p.blue = 8'd0;
      end
      if (knock_cfg) begin
         p.red = 8'd0;
         p.green = 8'd0;
         p.blue = 8'd0;
         p.white = 8'd0;
      end

      span = t.now_ms - last_step_ms;
      p.suppress_light = knock_cfg;
      p.tx_state = cur_state[3:0];
      p.generation_out = steps_taken;
      p.phase_ms = span[15:0];
      p.intensity = level[7:0];
      return p;
   endfunction

   function automatic void queue_tick(input logic [31:0] now_ms, input logic [7:0] divider,
                                      input logic presence, input logic [2:0] count,
                                      input logic [23:0] states, input logic drain_first);
      tick_beat_type t;
      t.drain_first = drain_first;
      t.now_ms = now_ms;
      t.tick_divider = divider;
      t.presence_rising = presence;
      t.neighbor_count = count;
      t.neighbor_states = states;
      tick_queue.push_back(t);
   endfunction

   // A register write takes effect at the edge after the one that drives it.
   // It is only issued while nothing is in flight, so the predictor copy can
   // be updated at once.
   task automatic write_reg(input emc_pkg::csr_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      case (idx)
         emc_pkg::REG_EXCITE_THRESHOLD: threshold_cfg = value[7:0];
         emc_pkg::REG_SPARK_CHANCE:     spark_cfg = value[7:0];
         emc_pkg::REG_REFRACTORY_LEN:   refractory_cfg = value[7:0];
         emc_pkg::REG_TICK_PERIOD_MS:   period_cfg = value[14:0];
         emc_pkg::REG_HUE_SEL:          hue_cfg = value[7:0];
         emc_pkg::REG_KNOCK_MODE:       knock_cfg = value[0];
         emc_pkg::REG_PRESENCE_SEED:    seed_enable_cfg = value[0];
         // Writing the seed reloads the generator immediately.
         emc_pkg::REG_RNG_SEED:
            spark_word = (value == 32'd0) ? emc_pkg::RNG_DEFAULT_SEED : value;
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Waits until every queued tick has been taken and answered, then lets
   // the pipeline settle before returning on a falling edge.
   task automatic wait_idle();
      while (tick_queue.size() != 0 || due_pixels.size() != 0 || req_ch.valid)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic check_field(input string fname, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         fault_count++;
         if (fault_count <= MAX_REPORTS)
            $display("mismatch in %s at result %0d: expected %0d, got %0d",
                     fname, results_seen, want, got);
      end
   endtask

   // Driver. A tick beat is predicted at the edge where it is accepted. After
   // an accepted beat the sender may go quiet for a short random burst. A
   // tick marked drain_first is held back until every earlier pixel is back.
   always @(posedge clock) begin
      logic valid_next;
      logic load;
      tick_beat_type offered;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         valid_next = req_ch.valid;
         load = 1'b0;
         if (req_ch.valid && req_ch.ready) begin
            due_pixels.push_back(step_cell(offered));
            valid_next = 1'b0;
            if (!calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 5);
         end
         if (!valid_next) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (tick_queue.size() != 0 &&
                         !(tick_queue[0].drain_first && due_pixels.size() != 0)) begin
               offered = tick_queue.pop_front();
               valid_next = 1'b1;
               load = 1'b1;
            end
         end
         // The valid line gets exactly one assignment per edge, so back-to-back
         // beats keep it high without a glitch.
         req_ch.valid <= valid_next;
         if (load) begin
            req_ch.now_ms <= offered.now_ms;
            req_ch.tick_divider <= offered.tick_divider;
            req_ch.presence_rising <= offered.presence_rising;
            req_ch.neighbor_count <= offered.neighbor_count;
            req_ch.neighbor_states <= offered.neighbor_states;
         end
      end
   end

   // Long receiver hold. This process counts result beats on its own and,
   // once the count is reached, keeps the receiver off for a fixed stretch.
   always @(posedge clock) begin
      if (reset) begin
         hold_on <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            hold_seen++;
            if (hold_seen == HOLD_AT) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) hold_left--;
         hold_on <= (hold_left > 0);
      end
   end

   // Monitor. Each accepted pixel beat is checked against the oldest
   // prediction. The ready line stalls in short random bursts, and once in the
   // run it is held low long enough for the block to back up onto its input.
   always @(posedge clock) begin
      pixel_beat_type got;
      pixel_beat_type want;
      logic ready_next;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.send_now = rsp_ch.send_now;
            got.strike_request = rsp_ch.strike_request;
            got.strike_pulse_ms = rsp_ch.strike_pulse_ms;
            got.suppress_light = rsp_ch.suppress_light;
            got.tx_state = rsp_ch.tx_state;
            got.generation_out = rsp_ch.generation_out;
            got.phase_ms = rsp_ch.phase_ms;
            got.intensity = rsp_ch.intensity;
            got.red = rsp_ch.red;
            got.green = rsp_ch.green;
            got.blue = rsp_ch.blue;
            got.white = rsp_ch.white;
            results_seen++;
            if (due_pixels.size() == 0) begin
               fault_count++;
               if (fault_count <= MAX_REPORTS)
                  $display("result %0d arrived with no tick outstanding", results_seen);
            end else begin
               want = due_pixels.pop_front();
               check_field("send_now", want.send_now, got.send_now);
               check_field("strike_request", want.strike_request, got.strike_request);
               check_field("strike_pulse_ms", want.strike_pulse_ms, got.strike_pulse_ms);
               check_field("suppress_light", want.suppress_light, got.suppress_light);
               check_field("tx_state", want.tx_state, got.tx_state);
               check_field("generation_out", want.generation_out, got.generation_out);
               check_field("phase_ms", want.phase_ms, got.phase_ms);
               check_field("intensity", want.intensity, got.intensity);
               check_field("red", want.red, got.red);
               check_field("green", want.green, got.green);
               check_field("blue", want.blue, got.blue);
               check_field("white", want.white, got.white);
            end
         end
         if (hold_on) begin
            ready_next = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            // This cycle opens a stall burst whose further length is drawn into stall_left.
            stall_left = $urandom_range(0, 4);
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_ch.ready <= ready_next;
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // Stimulus and phase control.
   initial begin
      int          p, n, ticks, sel, seg;
      logic [31:0] wall_ms, period_eff, span;
      logic [7:0]  div, new_thr, new_spark, new_refr, new_hue;
      logic [14:0] new_period;
      logic        new_knock, new_seed_en;
      logic [31:0] new_seed;
      logic [23:0] states;
      logic        long_run;

      // Every input of the block is known from time zero.
      req_ch.valid = 1'b0;
      req_ch.now_ms = 32'd0;
      req_ch.tick_divider = 8'd0;
      req_ch.presence_rising = 1'b0;
      req_ch.neighbor_count = 3'd0;
      req_ch.neighbor_states = 24'd0;
      rsp_ch.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = emc_pkg::REG_EXCITE_THRESHOLD;
      csr_write_data = 32'd0;

      // Predictor starts from the reset defaults.
      threshold_cfg = emc_pkg::RST_EXCITE_THRESHOLD;
      spark_cfg = emc_pkg::RST_SPARK_CHANCE;
      refractory_cfg = emc_pkg::RST_REFRACTORY_LEN;
      period_cfg = emc_pkg::RST_TICK_PERIOD_MS;
      hue_cfg = emc_pkg::RST_HUE_SEL;
      knock_cfg = 1'b0;
      seed_enable_cfg = 1'b0;
      cur_state = emc_pkg::CELL_QUIESCENT;
      steps_taken = 16'd0;
      spark_word = emc_pkg::RNG_DEFAULT_SEED;
      last_step_ms = 32'd0;
      excited_at_ms = 32'd0;
      seed_latched = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed run at the reset settings, one second per step.
      // A tick at time zero leaves the cell unstarted; the next one starts it.
      queue_tick(32'd0, 8'd0, 1'b0, 3'd0, 24'h000000, 1'b0);
      queue_tick(32'd5, 8'd1, 1'b0, 3'd0, 24'h000000, 1'b0);
      // All six neighbors excited, with a presence edge that is ignored here.
      queue_tick(32'd1005, 8'd1, 1'b1, 3'd6, 24'h111111, 1'b0);
      // The attack ramp part way up and then at full level.
      queue_tick(32'd1100, 8'd1, 1'b0, 3'd6, 24'h111111, 1'b0);
      queue_tick(32'd1205, 8'd1, 1'b0, 3'd6, 24'h111111, 1'b0);
      // Walk through the refractory states and back to quiescent; a zero
      // divider acts as one.
      queue_tick(32'd2005, 8'd0, 1'b0, 3'd1, 24'h000001, 1'b0);
      queue_tick(32'd3005, 8'd1, 1'b0, 3'd2, 24'h000010, 1'b0);
      queue_tick(32'd4005, 8'd1, 1'b0, 3'd3, 24'h000100, 1'b0);
      queue_tick(32'd5005, 8'd1, 1'b0, 3'd4, 24'h001000, 1'b0);
      // A neighbor count above the slot limit, with no neighbor excited.
      queue_tick(32'd6005, 8'd1, 1'b0, 3'd7, 24'hFFFFFF, 1'b0);
      // Time runs across the 32-bit wrap, then lands on zero so the cell
      // has to start over.
      queue_tick(32'hFFFF_FFFF, 8'd255, 1'b1, 3'd0, 24'h000000, 1'b0);
      queue_tick(32'h0000_03E7, 8'd1, 1'b0, 3'd6, 24'hEEEEEE, 1'b0);
      queue_tick(32'd0, 8'd1, 1'b0, 3'd5, 24'h222222, 1'b0);
      queue_tick(32'd10, 8'd1, 1'b0, 3'd0, 24'h000000, 1'b0);
      wait_idle();

      // Knock mode with presence seeding; only a seed can excite the cell now.
      write_reg(emc_pkg::REG_KNOCK_MODE, 32'd1);
      write_reg(emc_pkg::REG_PRESENCE_SEED, 32'd1);
      write_reg(emc_pkg::REG_EXCITE_THRESHOLD, 32'd255);
      write_reg(emc_pkg::REG_SPARK_CHANCE, 32'd0);
      write_reg(emc_pkg::REG_HUE_SEL, 32'd255);
      @(negedge clock);
      queue_tick(32'd1010, 8'd1, 1'b1, 3'd6, 24'h111111, 1'b0);
      queue_tick(32'd1500, 8'd1, 1'b0, 3'd6, 24'h111111, 1'b0);
      queue_tick(32'd2010, 8'd1, 1'b0, 3'd0, 24'h000000, 1'b0);
      // A presence edge while refractory stays latched until the cell rests.
      queue_tick(32'd3010, 8'd1, 1'b1, 3'd0, 24'h000000, 1'b0);
      queue_tick(32'd4010, 8'd1, 1'b0, 3'd0, 24'h000000, 1'b0);
      queue_tick(32'd5010, 8'd1, 1'b0, 3'd0, 24'h000000, 1'b0);
      queue_tick(32'd6010, 8'd1, 1'b0, 3'd0, 24'h000000, 1'b0);
      queue_tick(32'd7010, 8'd1, 1'b0, 3'd0, 24'h000000, 1'b0);
      wall_ms = 32'd7010;

      // Random phases. Each one rewrites every register while the block is
      // idle, then runs a batch of ticks whose times mostly land just past
      // the step period so the cell keeps cycling through its states.
      for (p = 0; p < PHASES; p++) begin
         wait_idle();
         if (p == PHASES - 1) calm = 1'b1;
         seg = p % HUE_SEGMENTS;
         new_hue = 8'(seg * emc_pkg::HUE_SPAN + $urandom_range(0, (seg == 5) ? 40 : 42));
         case (p)
            0: begin
               new_thr = 8'd1; new_spark = 8'd0; new_refr = 8'd1;
               new_period = 15'd100; new_hue = 8'd0; new_knock = 1'b0;
               new_seed_en = 1'b1; new_seed = 32'd1;
            end
            1: begin
               new_thr = 8'd255; new_spark = 8'd255; new_refr = 8'd2;
               new_period = 15'd25500; new_hue = 8'd255; new_knock = 1'b0;
               new_seed_en = 1'b0; new_seed = 32'hFFFF_FFFF;
            end
            2: begin
               // Zero settings fall back to their defaults.
               new_thr = 8'd0; new_spark = 8'd40; new_refr = 8'd0;
               new_period = 15'd0; new_knock = 1'b1;
               new_seed_en = 1'b1; new_seed = 32'd0;
            end
            LONG_PHASE: begin
               // The longest refractory run, long enough to see the state wrap.
               new_thr = 8'd1; new_spark = 8'd255; new_refr = 8'd255;
               new_period = 15'd100; new_knock = 1'b0;
               new_seed_en = 1'b0; new_seed = $urandom;
            end
            default: begin
               new_thr = 8'($urandom_range(1, 4));
               new_spark = 8'($urandom_range(0, 64));
               new_refr = 8'($urandom_range(1, 8));
               new_period = 15'($urandom_range(100, 3000));
               new_knock = (p % 4 == 3);
               new_seed_en = p[0];
               new_seed = $urandom;
            end
         endcase
         write_reg(emc_pkg::REG_EXCITE_THRESHOLD, 32'(new_thr));
         write_reg(emc_pkg::REG_SPARK_CHANCE, 32'(new_spark));
         write_reg(emc_pkg::REG_REFRACTORY_LEN, 32'(new_refr));
         write_reg(emc_pkg::REG_TICK_PERIOD_MS, 32'(new_period));
         write_reg(emc_pkg::REG_HUE_SEL, 32'(new_hue));
         write_reg(emc_pkg::REG_KNOCK_MODE, 32'(new_knock));
         write_reg(emc_pkg::REG_PRESENCE_SEED, 32'(new_seed_en));
         write_reg(emc_pkg::REG_RNG_SEED, new_seed);
         @(negedge clock);

         long_run = (p == LONG_PHASE);
         ticks = long_run ? LONG_TICKS : PHASE_TICKS;
         period_eff = (period_cfg == 15'd0) ? 32'(emc_pkg::DEFAULT_PERIOD_MS)
                                            : 32'(period_cfg);
         for (n = 0; n < ticks; n++) begin
            sel = $urandom_range(0, 9);
            if (long_run) div = 8'($urandom_range(0, 1));
            else if (sel < 4) div = 8'd1;
            else if (sel < 6) div = 8'd0;
            else if (sel < 8) div = 8'($urandom_range(2, 3));
            else if (sel < 9) div = 8'($urandom_range(0, 255));
            else div = 8'd255;
            span = period_eff * ((div == 8'd0) ? 32'd1 : 32'(div));
            // Most ticks step; some fall short of the period, and a few jump
            // to an arbitrary time or to zero.
            sel = long_run ? 0 : $urandom_range(0, 19);
            if (sel < 12) wall_ms = wall_ms + span + $urandom_range(0, period_eff / 2);
            else if (sel < 17) wall_ms = wall_ms + $urandom_range(0, span - 1);
            else if (sel < 19) wall_ms = $urandom;
            else wall_ms = 32'd0;
            for (int i = 0; i < emc_pkg::MAX_NEIGHBORS; i++)
               states[4*i +: 4] = $urandom_range(0, 1) ? emc_pkg::NEIGH_EXCITED
                                                       : 4'($urandom_range(0, 15));
            queue_tick(wall_ms, div, ($urandom_range(0, 4) == 0),
                       3'($urandom_range(0, 7)), states,
                       (p == DRAIN_PHASE && n == ticks / 2));
         end
      end

      wait_idle();
      if (fault_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
